[rtl/core/ffha_pkg.sv]
package ffha_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_SPLIT,
    CMD_MERGE
  } cmd_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_op_t     op;
    entry_t      wr;
    logic [16:0] a;
  } cmd_t;

  // what the selected cell and its right neighbor show
  typedef struct packed {
    entry_t ent;
    logic   rfree;
  } view_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_DISPATCH,
    S_FIND_USED,
    S_FIT,
    S_GROW,
    S_SPLIT,
    S_FIND_START,
    S_MARK_FREE,
    S_COAL_R,
    S_COAL_L,
    S_DONE
  } state_t;

endpackage

[rtl/core/ffha_cell.sv]
module ffha_cell #(
  parameter int IDX          = 0,
  parameter int CNT_W        = 7,
  parameter int HEADER_BYTES = 32
) (
  input  logic               clk,
  input  ffha_pkg::cmd_t     cmd,
  input  logic [CNT_W-1:0]   k,
  input  ffha_pkg::entry_t   left,
  input  ffha_pkg::entry_t   right,
  output ffha_pkg::entry_t   ent
);

  localparam logic [CNT_W:0] ME = (CNT_W+1)'(IDX);
  localparam logic [15:0]    HDR = 16'(HEADER_BYTES);

  logic [CNT_W:0] kx;
  logic           is_me;
  logic           is_next;
  logic           past_k;
  logic           past_next;

  assign kx        = {1'b0, k};
  assign is_me     = (kx == ME);
  assign is_next   = (kx + 1'b1 == ME);
  assign past_k    = (kx < ME);
  assign past_next = (kx + 1'b1 < ME);

  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::CMD_WRITE: begin
        if (is_me) ent <= cmd.wr;
      end
      ffha_pkg::CMD_SPLIT: begin
        if (is_me) begin
          ent.size <= cmd.a[15:0];
        end else if (is_next) begin
          // remainder of the left neighbor becomes a free block
          ent.start <= left.start + HDR + cmd.a[15:0];
          ent.size  <= left.size - cmd.a[15:0] - HDR;
          ent.free  <= 1'b1;
        end else if (past_next) begin
          ent <= left;
        end
      end
      ffha_pkg::CMD_MERGE: begin
        if (is_me) begin
          ent.size <= right.start + right.size - ent.start;
        end else if (past_k) begin
          ent <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/ffha_chain.sv]
module ffha_chain #(
  parameter int MAX_BLOCKS   = 64,
  parameter int CNT_W        = 7,
  parameter int HEADER_BYTES = 32
) (
  input  logic             clk,
  input  ffha_pkg::cmd_t   cmd,
  input  logic [CNT_W-1:0] k,
  output ffha_pkg::view_t  view
);

  ffha_pkg::entry_t ent [MAX_BLOCKS];
  ffha_pkg::entry_t lft [MAX_BLOCKS];
  ffha_pkg::entry_t rgt [MAX_BLOCKS];

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lft[i] = '0;
    end else begin : g_mid_l
      assign lft[i] = ent[i-1];
    end
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign rgt[i] = '0;
    end else begin : g_mid_r
      assign rgt[i] = ent[i+1];
    end

    ffha_cell #(
      .IDX          (i),
      .CNT_W        (CNT_W),
      .HEADER_BYTES (HEADER_BYTES)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .k     (k),
      .left  (lft[i]),
      .right (rgt[i]),
      .ent   (ent[i])
    );
  end

  // one-hot select onto the view bus
  always_comb begin
    view = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (k == CNT_W'(i)) begin
        view.ent   = ent[i];
        view.rfree = rgt[i].free;
      end
    end
  end

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator over a row of MAX_BLOCKS table cells kept in address
// order. One request is taken at a time. Every request first rounds its size up
// to ALIGN_BYTES with a reciprocal multiply, then walks the cell chain one entry
// per cycle for the address lookup and for the first-fit search; a fitting block
// is split when its rest can hold a free block, and coalescing merges free
// neighbors first on the right and then on the left. A moving resize adds a
// second walk to find the old block. The finished result sits in an output
// register and the next request is taken once it has been loaded.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] req_size,
  input  logic [15:0] req_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_addr,
  output logic [1:0]  status,
  output logic        moved,
  output logic [15:0] copy_bytes
);

  localparam int          CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int          AL_SH   = 17 + $clog2(ALIGN_BYTES);
  localparam logic [18:0] AL_M    =
    19'(((longint'(1) << AL_SH) + longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES));
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
  localparam logic [16:0] LIM_CAP = (HEAP_BYTES < 65536) ? 17'(HEAP_BYTES) : 17'd65536;
  localparam logic [17:0] HDR     = 18'(HEADER_BYTES);
  localparam logic [17:0] ALN     = 18'(ALIGN_BYTES);

  ffha_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] k, k_next;
  logic [16:0]      top, top_next;
  logic [16:0]      limit_reg;
  logic [16:0]      n, n_next;
  logic             phase, phase_next;
  logic [16:0]      a, a_next;
  logic [1:0]       op_q, op_q_next;
  logic [15:0]      size_q, size_q_next;
  logic [15:0]      addr_q, addr_q_next;
  logic             moving, moving_next;
  logic [15:0]      old_start, old_start_next;
  logic [15:0]      old_size, old_size_next;
  logic [15:0]      res, res_next;
  logic [1:0]       st, st_next;
  logic             load_out;

  ffha_pkg::cmd_t   cmd;
  logic [CNT_W-1:0] cmd_k;
  ffha_pkg::view_t  view;

  logic [16:0] lim;
  logic [35:0] al_prod;
  logic [16:0] al_q;
  logic [23:0] al_a;
  logic [17:0] grow_end;

  ffha_chain #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .CNT_W        (CNT_W),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .k    (cmd_k),
    .view (view)
  );

  assign lim      = (limit_reg < LIM_CAP) ? limit_reg : LIM_CAP;
  assign al_prod  = {19'd0, n} * {17'd0, AL_M};
  assign al_q     = 17'(al_prod >> AL_SH);
  assign al_a     = {7'd0, n} * 24'(ALIGN_BYTES);
  assign grow_end = {1'b0, top} + HDR + {1'b0, a};
  assign in_ready = (state == ffha_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    top_next       = top;
    n_next         = n;
    phase_next     = phase;
    a_next         = a;
    op_q_next      = op_q;
    size_q_next    = size_q;
    addr_q_next    = addr_q;
    moving_next    = moving;
    old_start_next = old_start;
    old_size_next  = old_size;
    res_next       = res;
    st_next        = st;
    load_out       = 1'b0;
    cmd.op         = ffha_pkg::CMD_NONE;
    cmd.wr         = view.ent;
    cmd.a          = a;
    cmd_k          = k;

    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (in_valid) begin
          op_q_next   = op;
          size_q_next = req_size;
          addr_q_next = req_addr;
          n_next      = 17'(req_size) + 17'(ALIGN_BYTES - 1);
          phase_next  = 1'b1;
          moving_next = 1'b0;
          res_next    = '0;
          st_next     = ffha_pkg::ST_OK;
          state_next  = ffha_pkg::S_ALIGN;
        end
      end
      ffha_pkg::S_ALIGN: begin
        // quotient by reciprocal multiply, then scale back by the alignment
        if (phase) begin
          n_next     = al_q;
          phase_next = 1'b0;
        end else begin
          a_next     = al_a[16:0];
          state_next = ffha_pkg::S_DISPATCH;
        end
      end
      ffha_pkg::S_DISPATCH: begin
        k_next = '0;
        if (op_q == ffha_pkg::OP_FREE) begin
          if (addr_q == 16'd0) begin
            st_next    = ffha_pkg::ST_NULL;
            state_next = ffha_pkg::S_DONE;
          end else begin
            state_next = ffha_pkg::S_FIND_USED;
          end
        end else if (op_q == ffha_pkg::OP_RESIZE && addr_q != 16'd0) begin
          state_next = ffha_pkg::S_FIND_USED;
        end else if (size_q == 16'd0) begin
          st_next    = ffha_pkg::ST_NULL;
          state_next = ffha_pkg::S_DONE;
        end else begin
          state_next = ffha_pkg::S_FIT;
        end
      end
      ffha_pkg::S_FIND_USED: begin
        if (k == cnt) begin
          st_next    = ffha_pkg::ST_UNKNOWN;
          state_next = ffha_pkg::S_DONE;
        end else if (!view.ent.free &&
                     ({2'b0, view.ent.start} + HDR == {2'b0, addr_q})) begin
          if (op_q == ffha_pkg::OP_FREE) begin
            state_next = ffha_pkg::S_MARK_FREE;
          end else if (size_q == 16'd0) begin
            st_next    = ffha_pkg::ST_NULL;
            state_next = ffha_pkg::S_MARK_FREE;
          end else if ({1'b0, view.ent.size} >= a) begin
            res_next   = addr_q;
            state_next = ffha_pkg::S_SPLIT;
          end else begin
            old_start_next = view.ent.start;
            old_size_next  = view.ent.size;
            moving_next    = 1'b1;
            k_next         = '0;
            state_next     = ffha_pkg::S_FIT;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ffha_pkg::S_FIT: begin
        if (k == cnt) begin
          state_next = ffha_pkg::S_GROW;
        end else if (view.ent.free && {1'b0, view.ent.size} >= a) begin
          cmd.op      = ffha_pkg::CMD_WRITE;
          cmd.wr.free = 1'b0;
          res_next    = 16'({2'b0, view.ent.start} + HDR);
          state_next  = ffha_pkg::S_SPLIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ffha_pkg::S_GROW: begin
        if (cnt >= MAXC || grow_end > {1'b0, lim}) begin
          st_next     = ffha_pkg::ST_OOM;
          res_next    = '0;
          moving_next = 1'b0;
          state_next  = ffha_pkg::S_DONE;
        end else begin
          cmd.op       = ffha_pkg::CMD_WRITE;
          cmd.wr.start = top[15:0];
          cmd.wr.size  = a[15:0];
          cmd.wr.free  = 1'b0;
          cmd_k        = cnt;
          cnt_next     = cnt + 1'b1;
          top_next     = grow_end[16:0];
          res_next     = 16'({1'b0, top} + HDR);
          k_next       = '0;
          state_next   = moving ? ffha_pkg::S_FIND_START : ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_SPLIT: begin
        if ({2'b0, view.ent.size} >= {1'b0, a} + HDR + ALN && cnt < MAXC) begin
          cmd.op   = ffha_pkg::CMD_SPLIT;
          cnt_next = cnt + 1'b1;
        end
        k_next     = '0;
        state_next = moving ? ffha_pkg::S_FIND_START : ffha_pkg::S_DONE;
      end
      ffha_pkg::S_FIND_START: begin
        if (k == cnt) begin
          state_next = ffha_pkg::S_DONE;
        end else if (view.ent.start == old_start) begin
          state_next = ffha_pkg::S_MARK_FREE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ffha_pkg::S_MARK_FREE: begin
        cmd.op      = ffha_pkg::CMD_WRITE;
        cmd.wr.free = 1'b1;
        state_next  = ffha_pkg::S_COAL_R;
      end
      ffha_pkg::S_COAL_R: begin
        if ({1'b0, k} + 1'b1 < {1'b0, cnt} && view.rfree) begin
          cmd.op   = ffha_pkg::CMD_MERGE;
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = ffha_pkg::S_COAL_L;
        end
      end
      ffha_pkg::S_COAL_L: begin
        // view sits on the left neighbor, which absorbs this block
        if (k != '0) cmd_k = k - 1'b1;
        if (k != '0 && view.ent.free) begin
          cmd.op   = ffha_pkg::CMD_MERGE;
          k_next   = k - 1'b1;
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_IDLE;
      cnt       <= '0;
      top       <= '0;
      limit_reg <= 17'd65536;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      top   <= top_next;
      if (cfg_wr_en) limit_reg <= cfg_wr_data;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    n         <= n_next;
    phase     <= phase_next;
    a         <= a_next;
    op_q      <= op_q_next;
    size_q    <= size_q_next;
    addr_q    <= addr_q_next;
    moving    <= moving_next;
    old_start <= old_start_next;
    old_size  <= old_size_next;
    res       <= res_next;
    st        <= st_next;
    if (load_out) begin
      result_addr <= res;
      status      <= st;
      moved       <= moving;
      copy_bytes  <= moving ? old_size : 16'd0;
    end
  end

endmodule

[rtl/core/ffha_checker.sv]
module ffha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_addr,
  input logic [1:0]  status,
  input logic        moved,
  input logic [15:0] copy_bytes
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_null_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ffha_pkg::ST_OOM || status == ffha_pkg::ST_UNKNOWN ||
                  status == ffha_pkg::ST_NULL) |-> result_addr == 16'd0 && !moved)
    else $error("failed request gave an address or a move");

  a_copy_only_moved: assert property (@(posedge clk) disable iff (rst)
    out_valid && !moved |-> copy_bytes == 16'd0)
    else $error("copy size without a move");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_addr (result_addr),
  .status      (status),
  .moved       (moved),
  .copy_bytes  (copy_bytes)
);
